[hw/rtl/olir_pkg.sv]
`default_nettype none

package olir_pkg;

  localparam int DEPTH  = 64;
  localparam int ELEM_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_APPEND     = 3'd1,
    OP_REMOVE_AT  = 3'd2,
    OP_REMOVE_VAL = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_SCAN_RD,
    S_SCAN_CMP
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ELEM_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

[hw/rtl/olir_ram.sv]
`default_nettype none

module olir_ram (
  input  wire                      clk_i,
  input  olir_pkg::ram_req_t       req_i,
  output logic [olir_pkg::ELEM_W-1:0] rdata_o
);
  import olir_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[req_i.raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/ordered_list_insert_remove_top.sv]
`default_nettype none
// an insert or a remove at position moves list entries one at a time to open or close the gap at
// the position; a remove by value scans the list and, on a match, closes the gap behind it
// items are taken one at a time; busy_o drops with the result strobe and a new item may
// start in that cycle; the receiver cannot stall
// reset clears the count; the list memory is not cleared
module ordered_list_insert_remove_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  output logic                           busy_o,
  input  wire  [olir_pkg::OP_W-1:0]      operation_i,
  input  wire  [olir_pkg::POS_W-1:0]     position_i,
  input  wire  [olir_pkg::ELEM_W-1:0]    value_i,
  output logic                           done_o,
  output logic [olir_pkg::STAT_W-1:0]    status_o,
  output logic [olir_pkg::ELEM_W-1:0]    read_data_o,
  output logic [olir_pkg::CNT_W-1:0]     entry_count_o,
  output logic                           list_empty_o,
  output logic                           list_full_o
);
  import olir_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [ELEM_W-1:0] val_q;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [ELEM_W-1:0] rdata_q, rdata_d;

  ram_req_t          ram_req;
  logic [ELEM_W-1:0] ram_rdata;

  logic              accept;
  logic [CNT_W-1:0]  idx_inc, idx_dec;
  logic [POS_W-1:0]  ins_pos;
  logic              hit;

  assign accept  = start_i && (state_q == S_IDLE);
  assign idx_inc = idx_q + CNT_W'(1);
  assign idx_dec = idx_q - CNT_W'(1);
  assign hit     = (ram_rdata == val_q);
  assign ins_pos = (op_q == OP_APPEND) ? POS_W'(cnt_q) : pos_q;

  olir_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_IDLE;
        unique case (op_q)
          OP_INSERT, OP_APPEND: begin
            if (cnt_q != FULL_CNT && ins_pos <= POS_W'(cnt_q)) state_d = S_UP_RD;
          end
          OP_REMOVE_AT: begin
            if (pos_q < POS_W'(cnt_q)) state_d = S_DN_RD;
          end
          OP_REMOVE_VAL: state_d = S_SCAN_RD;
          OP_READ: begin
            if (pos_q < POS_W'(cnt_q)) state_d = S_UP_WR;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_UP_RD: begin
        state_d = (idx_q == CNT_W'(pos_q)) ? S_IDLE : S_UP_WR;
      end
      S_UP_WR: begin
        state_d = (op_q == OP_READ) ? S_IDLE : S_UP_RD;
      end
      S_DN_RD: begin
        state_d = (idx_inc >= cnt_q) ? S_IDLE : S_DN_WR;
      end
      S_DN_WR: state_d = S_DN_RD;
      S_SCAN_RD: begin
        state_d = (idx_q == cnt_q) ? S_IDLE : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        state_d = hit ? S_DN_RD : S_SCAN_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pos_d         = pos_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    done_d        = 1'b0;
    status_d      = status_q;
    rdata_d       = rdata_q;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx_q[ADDR_W-1:0];
    ram_req.wdata = ram_rdata;
    ram_req.raddr = idx_q[ADDR_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) pos_d = position_i;
      end
      S_DECODE: begin
        status_d = ST_DONE;
        rdata_d  = '0;
        unique case (op_q)
          OP_INSERT, OP_APPEND: begin
            pos_d = ins_pos;
            idx_d = cnt_q;
            if (cnt_q == FULL_CNT) begin
              status_d = ST_FULL;
              done_d   = 1'b1;
            end else if (ins_pos > POS_W'(cnt_q)) begin
              status_d = ST_RANGE;
              done_d   = 1'b1;
            end
          end
          OP_REMOVE_AT: begin
            idx_d = CNT_W'(pos_q);
            if (pos_q >= POS_W'(cnt_q)) begin
              status_d = ST_RANGE;
              done_d   = 1'b1;
            end
          end
          OP_REMOVE_VAL: idx_d = '0;
          OP_READ: begin
            ram_req.raddr = pos_q[ADDR_W-1:0];
            if (pos_q >= POS_W'(cnt_q)) begin
              status_d = ST_RANGE;
              done_d   = 1'b1;
            end
          end
          default: begin
            status_d = ST_RANGE;
            done_d   = 1'b1;
          end
        endcase
      end
      S_UP_RD: begin
        ram_req.raddr = idx_dec[ADDR_W-1:0];
        if (idx_q == CNT_W'(pos_q)) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = val_q;
          cnt_d         = cnt_q + CNT_W'(1);
          done_d        = 1'b1;
        end
      end
      S_UP_WR: begin
        if (op_q == OP_READ) begin
          rdata_d = ram_rdata;
          done_d  = 1'b1;
        end else begin
          ram_req.we = 1'b1;
          idx_d      = idx_dec;
        end
      end
      S_DN_RD: begin
        ram_req.raddr = idx_inc[ADDR_W-1:0];
        if (idx_inc >= cnt_q) begin
          cnt_d  = cnt_q - CNT_W'(1);
          done_d = 1'b1;
        end
      end
      S_DN_WR: begin
        ram_req.we = 1'b1;
        idx_d      = idx_inc;
      end
      S_SCAN_RD: begin
        if (idx_q == cnt_q) begin
          status_d = ST_MISSING;
          done_d   = 1'b1;
        end
      end
      S_SCAN_CMP: begin
        if (!hit) idx_d = idx_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      val_q <= value_i;
    end
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    rdata_q  <= rdata_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_data_o   = rdata_q;
  assign entry_count_o = cnt_q;
  assign list_empty_o  = (cnt_q == '0);
  assign list_full_o   = (cnt_q == FULL_CNT);

endmodule

`default_nettype wire

[test/ordered_list_insert_remove_top_tb.sv]
module ordered_list_insert_remove_top_tb;
  import olir_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int PHASE_ITEMS = 45;

  typedef struct {
    status_e           status;
    logic [ELEM_W-1:0] rdata;
    logic [CNT_W-1:0]  cnt;
    logic              empty;
    logic              full;
  } list_result_t;

  class list_shadow;
    logic [ELEM_W-1:0] entries [DEPTH];
    int count;
    list_result_t awaited[$];
    int errors;
    int checked;
    int status_seen [4];
    int full_hits;
    int empty_hits;

    function void drop(int at);
      int k;
      count--;
      for (k = at; k < count; k++) entries[k] = entries[k + 1];
    endfunction

    function void apply_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [ELEM_W-1:0] val);
      list_result_t r;
      int at;
      int k;
      r.status = ST_DONE;
      r.rdata = '0;
      at = pos;
      case (op)
        OP_INSERT, OP_APPEND: begin
          if (op == OP_APPEND) at = count;
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else if (at > count) begin
            r.status = ST_RANGE;
          end else begin
            for (k = count; k > at; k--) entries[k] = entries[k - 1];
            entries[at] = val;
            count++;
          end
        end
        OP_REMOVE_AT: begin
          if (at >= count) r.status = ST_RANGE;
          else drop(at);
        end
        OP_REMOVE_VAL: begin
          k = 0;
          while (k < count && entries[k] != val) k++;
          if (k < count) drop(k);
          else r.status = ST_MISSING;
        end
        OP_READ: begin
          if (at >= count) r.status = ST_RANGE;
          else r.rdata = entries[at];
        end
        default: r.status = ST_RANGE;
      endcase
      r.cnt = CNT_W'(count);
      r.empty = (count == 0);
      r.full = (count == DEPTH);
      status_seen[r.status]++;
      if (r.full) full_hits++;
      if (r.empty) empty_hits++;
      awaited = {awaited, r};
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void compare_result(logic [STAT_W-1:0] status, logic [ELEM_W-1:0] rdata,
                                 logic [CNT_W-1:0] cnt, logic empty, logic full);
      list_result_t r;
      if (awaited.size() == 0) begin
        $error("result strobe with no item outstanding");
        errors++;
        return;
      end
      r = awaited.pop_front();
      checked++;
      check_field("status", 64'(r.status), 64'(status));
      check_field("read_data", 64'(r.rdata), 64'(rdata));
      check_field("entry_count", 64'(r.cnt), 64'(cnt));
      check_field("list_empty", 64'(r.empty), 64'(empty));
      check_field("list_full", 64'(r.full), 64'(full));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [OP_W-1:0]    operation_i = '0;
  logic [POS_W-1:0]   position_i = '0;
  logic [ELEM_W-1:0]  value_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [STAT_W-1:0]  status_o;
  logic [ELEM_W-1:0]  read_data_o;
  logic [CNT_W-1:0]   entry_count_o;
  logic               list_empty_o;
  logic               list_full_o;

  list_shadow shadow = new();
  int idle_cycles = 0;
  int items_sent = 0;
  bit no_gaps = 1'b0;

  ordered_list_insert_remove_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .read_data_o   (read_data_o),
    .entry_count_o (entry_count_o),
    .list_empty_o  (list_empty_o),
    .list_full_o   (list_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      shadow.compare_result(status_o, read_data_o, entry_count_o, list_empty_o, list_full_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ordered_list_insert_remove_top_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [ELEM_W-1:0] val);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    operation_i <= op;
    position_i <= pos;
    value_i <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    shadow.apply_op(op, pos, val);
    items_sent++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (shadow.pending() != 0);
  endtask

  function automatic logic [ELEM_W-1:0] rand_value();
    return ($urandom_range(0, 2) == 0) ? ELEM_W'($urandom_range(0, 7)) : ELEM_W'($urandom);
  endfunction

  task automatic random_item(bit grow);
    int pick;
    int cnt;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [ELEM_W-1:0] val;
    pick = $urandom_range(0, 99);
    cnt = shadow.count;
    if (grow) begin
      if (pick < 40) op = OP_INSERT;
      else if (pick < 70) op = OP_APPEND;
      else if (pick < 76) op = OP_REMOVE_AT;
      else if (pick < 82) op = OP_REMOVE_VAL;
      else if (pick < 95) op = OP_READ;
      else op = OP_W'($urandom_range(5, 7));
    end else begin
      if (pick < 8) op = OP_INSERT;
      else if (pick < 15) op = OP_APPEND;
      else if (pick < 45) op = OP_REMOVE_AT;
      else if (pick < 75) op = OP_REMOVE_VAL;
      else if (pick < 95) op = OP_READ;
      else op = OP_W'($urandom_range(5, 7));
    end
    pos = POS_W'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 85) begin
      if (op == OP_INSERT) pos = POS_W'($urandom_range(0, cnt));
      else if (cnt > 0) pos = POS_W'($urandom_range(0, cnt - 1));
    end
    val = rand_value();
    if (op == OP_REMOVE_VAL && cnt > 0 && $urandom_range(0, 1) == 1) begin
      val = shadow.entries[$urandom_range(0, cnt - 1)];
    end
    send_item(op, pos, val);
  endtask

  initial begin
    int ph;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corner cases, then range, match and invalid-opcode cases on a short list
    send_item(OP_READ, 7'd0, 32'h0);
    send_item(OP_REMOVE_AT, 7'd0, 32'h0);
    send_item(OP_REMOVE_VAL, 7'd0, 32'h0);
    send_item(OP_INSERT, 7'd1, 32'h1);
    send_item(OP_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_item(OP_APPEND, 7'd127, 32'h0);
    send_item(OP_INSERT, 7'd1, 32'h5A5A_5A5A);
    send_item(OP_INSERT, 7'd3, 32'hA5A5_A5A5);
    send_item(OP_INSERT, 7'd5, 32'h1);
    send_item(OP_READ, 7'd127, 32'h0);
    send_item(OP_READ, 7'd1, 32'h0);
    send_item(OP_READ, 7'd4, 32'h0);
    send_item(OP_REMOVE_VAL, 7'd0, 32'h5A5A_5A5A);
    send_item(OP_REMOVE_VAL, 7'd0, 32'h1234_5678);
    send_item(OP_REMOVE_AT, 7'd3, 32'h0);
    send_item(OP_REMOVE_AT, 7'd0, 32'h0);
    send_item(3'd5, 7'd0, 32'h0);
    send_item(3'd6, 7'd0, 32'h0);
    send_item(3'd7, 7'd127, 32'hFFFF_FFFF);
    drain();

    // fill to capacity, then the full-list cases
    while (shadow.count < DEPTH) send_item(OP_APPEND, POS_W'($urandom_range(0, 127)), rand_value());
    send_item(OP_INSERT, 7'd127, 32'h2);
    send_item(OP_APPEND, 7'd0, 32'h3);
    send_item(OP_INSERT, 7'd0, 32'h4);
    send_item(OP_READ, 7'(DEPTH - 1), 32'h0);
    send_item(OP_READ, 7'(DEPTH), 32'h0);
    send_item(OP_REMOVE_AT, 7'(DEPTH), 32'h0);
    drain();

    for (ph = 0; ph < 7; ph++) begin
      no_gaps = (ph % 3 == 2);
      repeat (PHASE_ITEMS) random_item(ph % 2 == 1);
      drain();
    end
    no_gaps = 1'b0;
    repeat (20) @(posedge clk_i);

    if (shadow.pending() != 0) begin
      $error("%0d results never arrived", shadow.pending());
      shadow.errors++;
    end
    $display("%0d items driven, %0d results compared; list ended full %0d times, empty %0d times",
             items_sent, shadow.checked, shadow.full_hits, shadow.empty_hits);
    $display("outcomes done/range/full/missing: %0d/%0d/%0d/%0d",
             shadow.status_seen[0], shadow.status_seen[1], shadow.status_seen[2],
             shadow.status_seen[3]);
    if (shadow.errors == 0) begin
      $display("ordered_list_insert_remove_top_tb: done, clean");
    end else begin
      $display("ordered_list_insert_remove_top_tb: done, errors");
    end
    $finish;
  end

endmodule
